### rtl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg - shared constants for the channel histogram chi-square block
// Bin and channel geometry, result widths, queue depth and word layout.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int HCS_COUNT_BITS = 24;
    localparam int BIN_BITS       = 8;
    localparam int NUM_BINS       = 256;
    localparam int NUM_CHAN       = 3;
    localparam int CHAN_BITS      = 2;
    localparam int CHI_BITS       = 40;
    localparam int PCNT_BITS      = 24;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [CHAN_BITS-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_BITS-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_BITS-1:0] CH_BLUE  = 2'd2;

    localparam logic [CHI_BITS-1:0]  CHI_MAX   = {CHI_BITS{1'b1}};
    localparam logic [PCNT_BITS-1:0] PCNT_MAX  = {PCNT_BITS{1'b1}};

    // queue word: {red, green, blue, last, skip, ovf, n}
    function automatic int entry_bits(input int kw);
        return 3 * BIN_BITS + 3 + kw;
    endfunction

endpackage

### rtl/hcs_if.sv
// ----------------------------------------------------------------------------
// hcs_if - pixel and result channel interfaces
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hcs_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface hcs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [39:0] chi_square;
    logic [23:0] pixel_count;
    logic        count_overflow;
    logic        last_result;

    modport source (output valid, channel, chi_square, pixel_count, count_overflow,
                    last_result, input ready);
    modport sink   (input valid, channel, chi_square, pixel_count, count_overflow,
                    last_result, output ready);
endinterface

### rtl/hcs_fifo.sv
// ----------------------------------------------------------------------------
// hcs_fifo - short queue between front and back
// Register-based FIFO, head word shown combinationally.
// ----------------------------------------------------------------------------
module hcs_fifo import hcs_pkg::*; #(
    parameter int WIDTH = entry_bits(HCS_COUNT_BITS),
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/hcs_front.sv
// ----------------------------------------------------------------------------
// hcs_front - pixel intake and classification
// Counts pixels, marks those past the count limit, tags the image total.
// ----------------------------------------------------------------------------
module hcs_front import hcs_pkg::*; #(
    parameter int KW = HCS_COUNT_BITS,
    parameter int EW = entry_bits(HCS_COUNT_BITS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hcs_pix_if.sink       i_pix,
    input  logic          i_q_full,
    input  logic          i_clearing,
    output logic          o_q_push,
    output logic [EW-1:0] o_q_data
);
    logic [KW-1:0] r_seen;
    logic          r_drop;
    logic          full;
    logic [KW-1:0] n_seen;
    logic          n_drop;

    assign i_pix.ready = !i_q_full && !i_clearing;
    assign o_q_push    = i_pix.valid && i_pix.ready;

    // count limit check
    always_comb begin
        full   = (r_seen == {KW{1'b1}});
        n_seen = full ? r_seen : r_seen + 1'b1;
        n_drop = r_drop || full;
    end

    assign o_q_data = {i_pix.red, i_pix.green, i_pix.blue, i_pix.last_pixel,
                       full, n_drop, n_seen};

    // per-image count, restarts after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_drop <= 1'b0;
        end else if (o_q_push) begin
            if (i_pix.last_pixel) begin
                r_seen <= '0;
                r_drop <= 1'b0;
            end else begin
                r_seen <= n_seen;
                r_drop <= n_drop;
            end
        end
    end

endmodule

### rtl/hcs_back.sv
// ----------------------------------------------------------------------------
// hcs_back - histogram update, bin walk, division and result output
// Three bin banks, one multiplier, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module hcs_back import hcs_pkg::*; #(
    parameter int KW = HCS_COUNT_BITS,
    parameter int EW = entry_bits(HCS_COUNT_BITS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  logic [EW-1:0] i_q_data,
    output logic          o_q_pop,
    output logic          o_clearing,
    hcs_res_if.source     o_res
);
    localparam int SQW = 2 * KW + BIN_BITS;
    localparam int DW  = SQW + 16;
    localparam int CW  = $clog2(DW + 1);
    localparam int NW  = (KW > PCNT_BITS) ? KW : PCNT_BITS;
    localparam logic [DW-1:0] CHI_MAX_W = DW'(CHI_MAX);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_WR   = 7'b0000100,
        S_WALK = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [KW-1:0]       r_mem   [NUM_CHAN][NUM_BINS];
    logic [KW-1:0]       r_rdata [NUM_CHAN];
    logic [BIN_BITS-1:0] a_ra    [NUM_CHAN];
    logic [BIN_BITS-1:0] a_wa    [NUM_CHAN];
    logic [KW-1:0]       a_wd    [NUM_CHAN];
    logic                a_we    [NUM_CHAN];
    logic [BIN_BITS-1:0] head_px [NUM_CHAN];

    logic [BIN_BITS-1:0] r_px [NUM_CHAN];
    logic                r_last;
    logic                r_skip;
    logic                r_ovf;
    logic [KW-1:0]       r_n;
    logic [BIN_BITS:0]   r_addr;
    logic [1:0]          r_chan;
    logic                r_rv;
    logic                r_pv;
    logic [2*KW-1:0]     r_prod;
    logic [SQW-1:0]      r_acc;
    logic [DW-1:0]       r_dvd;
    logic [KW-1:0]       r_rem;
    logic [DW-1:0]       r_q;
    logic [CW-1:0]       r_cnt;

    logic                r_ovalid;
    logic [1:0]          r_ochan;
    logic [CHI_BITS-1:0] r_ochi;
    logic [PCNT_BITS-1:0] r_opc;
    logic                r_oovf;
    logic                r_olast;

    logic [KW:0]         div_t;
    logic                div_ge;
    logic [DW-1:0]       sub;
    logic [DW-1:0]       diff;
    logic [CHI_BITS-1:0] chi;
    logic [NW-1:0]       n_w;
    logic [PCNT_BITS-1:0] pc;
    logic [KW-1:0]       sel;

    assign head_px[0] = i_q_data[KW+26:KW+19];
    assign head_px[1] = i_q_data[KW+18:KW+11];
    assign head_px[2] = i_q_data[KW+10:KW+3];

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_clearing = (r_state == S_CLR);

    assign o_res.valid          = r_ovalid;
    assign o_res.channel        = r_ochan;
    assign o_res.chi_square     = r_ochi;
    assign o_res.pixel_count    = r_opc;
    assign o_res.count_overflow = r_oovf;
    assign o_res.last_result    = r_olast;

    // bank port control
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            a_ra[c] = (r_state == S_IDLE) ? head_px[c] : r_addr[BIN_BITS-1:0];
            a_wa[c] = (r_state == S_WR) ? r_px[c] : r_addr[BIN_BITS-1:0];
            a_wd[c] = (r_state == S_WR) ? r_rdata[c] + 1'b1 : '0;
            a_we[c] = ((r_state == S_WR) && !r_skip) || (r_state == S_CLR) ||
                      ((r_state == S_WALK) && !r_addr[BIN_BITS] && (r_chan == 2'(c)));
        end
    end

    // bin banks, read-before-write so the walk reads and clears together
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            r_rdata[c] <= r_mem[c][a_ra[c]];
            if (a_we[c]) begin
                r_mem[c][a_wa[c]] <= a_wd[c];
            end
        end
    end

    // divider step and result formatting
    always_comb begin
        div_t  = {r_rem, r_dvd[DW-1]};
        div_ge = (div_t >= {1'b0, r_n});
        sub    = DW'(r_n) << 8;
        diff   = r_q - sub;
        if ((r_n == '0) || (r_q < sub)) begin
            chi = '0;
        end else if (diff > CHI_MAX_W) begin
            chi = CHI_MAX;
        end else begin
            chi = diff[CHI_BITS-1:0];
        end
        n_w = NW'(r_n);
        pc  = (n_w > NW'(PCNT_MAX)) ? PCNT_MAX : PCNT_BITS'(n_w);
        sel = r_rdata[r_chan];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_addr == 9'(NUM_BINS - 1)) n_state = S_IDLE;
            S_IDLE: if (i_q_valid) n_state = S_WR;
            S_WR:   n_state = r_last ? S_WALK : S_IDLE;
            S_WALK: if (r_addr[BIN_BITS] && !r_rv && !r_pv) n_state = S_DIV;
            S_DIV:  if (r_cnt == CW'(DW - 1)) n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT: begin
                if (o_res.ready) begin
                    n_state = (r_chan == CH_BLUE) ? S_IDLE : S_WALK;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_addr   <= '0;
            r_chan   <= CH_RED;
            r_rv     <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLR: begin
                    r_addr <= (n_state == S_IDLE) ? '0 : r_addr + 1'b1;
                end
                S_WR: begin
                    r_chan <= CH_RED;
                    r_addr <= '0;
                    r_rv   <= 1'b0;
                    r_pv   <= 1'b0;
                end
                S_WALK: begin
                    if (!r_addr[BIN_BITS]) r_addr <= r_addr + 1'b1;
                    r_rv <= !r_addr[BIN_BITS];
                    r_pv <= r_rv;
                    r_cnt <= '0;
                end
                S_DIV: r_cnt <= r_cnt + 1'b1;
                S_FIN: r_ovalid <= 1'b1;
                S_OUT: begin
                    if (o_res.ready) begin
                        r_ovalid <= 1'b0;
                        r_addr   <= '0;
                        r_rv     <= 1'b0;
                        r_pv     <= 1'b0;
                        if (r_chan != CH_BLUE) r_chan <= r_chan + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int c = 0; c < NUM_CHAN; c++) r_px[c] <= head_px[c];
            r_last <= i_q_data[KW+2];
            r_skip <= i_q_data[KW+1];
            r_ovf  <= i_q_data[KW];
            r_n    <= i_q_data[KW-1:0];
        end
        r_prod <= (2*KW)'(sel) * (2*KW)'(sel);
        if ((r_state == S_WR) || ((r_state == S_OUT) && o_res.ready)) begin
            r_acc <= '0;
        end else if ((r_state == S_WALK) && r_pv) begin
            r_acc <= r_acc + SQW'(r_prod);
        end
        if (r_state == S_WALK) begin
            r_dvd <= {r_acc, 16'h0000};
            r_rem <= '0;
        end else if (r_state == S_DIV) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= div_ge ? KW'(div_t - {1'b0, r_n}) : KW'(div_t);
            r_q   <= {r_q[DW-2:0], div_ge};
        end
        if (r_state == S_FIN) begin
            r_ochan <= r_chan;
            r_ochi  <= chi;
            r_opc   <= pc;
            r_oovf  <= r_ovf;
            r_olast <= (r_chan == CH_BLUE);
        end
    end

`ifndef SYNTHESIS
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop from empty queue");
    a_last_is_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last_result) |-> (o_res.channel == CH_BLUE))
        else $error("end of run flagged on non-blue result");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> ((r_state == S_DIV) || (r_state == S_FIN)))
        else $error("divider left early");
`endif

endmodule

### rtl/channel_histogram_chi_square.sv
// ----------------------------------------------------------------------------
// channel_histogram_chi_square - per-channel histogram uniformity test
// RGB pixels build three 256-bin histograms; each image yields three
// chi-square results (8 fractional bits) and clears the histograms.
//
//   channel  dir  fields                                          role
//   i_pix    in   red, green, blue, last_pixel                    pixel word
//   o_res    out  channel, chi_square, pixel_count,               result word
//                 count_overflow, last_result
//
// Flow: the front takes one pixel a cycle into a 4-word queue when it has room
// and no clearing runs; the back reads a pixel's bins, writes count + 1, and
// only then takes the next. A last pixel adds per channel a 256-read bin walk,
// a bit-serial divide for 2*COUNT_BITS+24 quotient bits and a format step.
// Reset: a pass clears all 256 bins of each bank; no pixel is taken then.
// Stalls: a held result stalls the back only; the front fills the queue.
// ----------------------------------------------------------------------------
module channel_histogram_chi_square import hcs_pkg::*; #(
    parameter int COUNT_BITS = HCS_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcs_pix_if.sink   i_pix,
    hcs_res_if.source o_res
);
    localparam int EW = entry_bits(COUNT_BITS);

    logic          q_push;
    logic [EW-1:0] q_wdata;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [EW-1:0] q_rdata;
    logic          clearing;

    // intake
    hcs_front #(.KW(COUNT_BITS), .EW(EW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    // queue
    hcs_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // histogram and statistic
    hcs_back #(.KW(COUNT_BITS), .EW(EW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_res      (o_res)
    );

endmodule
